### rtl/sas_pkg.sv
// Shared constants, codes and item types for the sprite animation sequencer.
package sas_pkg;

  // Sizing of the sequence store
  localparam int SEQ_COUNT   = 16;
  localparam int SEQ_ENTRIES = 64;
  localparam int FRAME_COUNT = 256;

  // Field widths
  localparam int SEQ_W   = 4;
  localparam int POS_W   = 6;
  localparam int FRAME_W = 8;
  localparam int LEN_W   = 7;
  localparam int RATE_W  = 16;
  localparam int STAMP_W = 32;
  localparam int REQ_W   = 3;

  // Frame memory holds SEQ_ENTRIES rows per sequence, addressed {seq, pos}
  localparam int FRAME_DEPTH = SEQ_COUNT * SEQ_ENTRIES;
  localparam int FADDR_W     = SEQ_W + POS_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_LOAD_FRAME = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_DESC  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PLAY_FWD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PLAY_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd4;

  // Classified operation carried through the queue
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FRAME,
    OP_DESC,
    OP_PLAY_FWD,
    OP_PLAY_BACK,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SEQ_W-1:0]   seq_id;
    logic [POS_W-1:0]   entry_pos;
    logic [FRAME_W-1:0] frame_value;
    logic [LEN_W-1:0]   seq_length;
    logic [RATE_W-1:0]  seq_rate;
    logic               seq_loop;
    logic [STAMP_W-1:0] time_stamp;
  } item_t;

endpackage

### rtl/sas_front.sv
// Front end: classify input items, clamp descriptor lengths and queue them.
module sas_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sas_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sas_pkg::SEQ_W-1:0]     in_seq_id,
  input  logic [sas_pkg::POS_W-1:0]     in_entry_pos,
  input  logic [sas_pkg::FRAME_W-1:0]   in_frame_value,
  input  logic [sas_pkg::LEN_W-1:0]     in_seq_length,
  input  logic [sas_pkg::RATE_W-1:0]    in_seq_rate,
  input  logic                          in_seq_loop,
  input  logic [sas_pkg::STAMP_W-1:0]   in_time_stamp,
  output logic                          q_valid,
  output sas_pkg::item_t                q_item,
  input  logic                          q_pop
);

  sas_pkg::item_t                  dec_item;
  logic                            seq_ok;
  logic                            frame_ok;
  sas_pkg::item_t                  q_mem [sas_pkg::QUEUE_DEPTH];
  logic [sas_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sas_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sas_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            push;

  // Classify the request; drop loads and plays that name nothing stored
  always_comb begin
    seq_ok   = (32'(in_seq_id) < sas_pkg::SEQ_COUNT);
    frame_ok = seq_ok && (32'(in_entry_pos) < sas_pkg::SEQ_ENTRIES) &&
               (32'(in_frame_value) < sas_pkg::FRAME_COUNT);
    dec_item             = '0;
    dec_item.seq_id      = in_seq_id;
    dec_item.entry_pos   = in_entry_pos;
    dec_item.frame_value = in_frame_value;
    dec_item.seq_rate    = in_seq_rate;
    dec_item.seq_loop    = in_seq_loop;
    dec_item.time_stamp  = in_time_stamp;
    // clamp length into 1..SEQ_ENTRIES
    if (in_seq_length == '0) begin
      dec_item.seq_length = sas_pkg::LEN_W'(1);
    end else if (32'(in_seq_length) > sas_pkg::SEQ_ENTRIES) begin
      dec_item.seq_length = sas_pkg::LEN_W'(sas_pkg::SEQ_ENTRIES);
    end else begin
      dec_item.seq_length = in_seq_length;
    end
    case (in_req_type)
      sas_pkg::REQ_LOAD_FRAME: dec_item.op = frame_ok ? sas_pkg::OP_FRAME : sas_pkg::OP_NONE;
      sas_pkg::REQ_LOAD_DESC:  dec_item.op = seq_ok ? sas_pkg::OP_DESC : sas_pkg::OP_NONE;
      sas_pkg::REQ_PLAY_FWD:   dec_item.op = seq_ok ? sas_pkg::OP_PLAY_FWD : sas_pkg::OP_NONE;
      sas_pkg::REQ_PLAY_BACK:  dec_item.op = seq_ok ? sas_pkg::OP_PLAY_BACK : sas_pkg::OP_NONE;
      sas_pkg::REQ_TICK:       dec_item.op = sas_pkg::OP_TICK;
      default:                 dec_item.op = sas_pkg::OP_NONE;
    endcase
  end

  // Queue control
  assign in_ready = (32'(count_r) < sas_pkg::QUEUE_DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == sas_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == sas_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec_item;
    end
  end

endmodule

### rtl/sas_back.sv
// Back end: sequence tables, frame memory, playback state and result register.
module sas_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sas_pkg::SEQ_W-1:0]     cfg_wdata,
  input  logic                          q_valid,
  input  sas_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sas_pkg::FRAME_W-1:0]   out_shown_frame_out,
  output logic [sas_pkg::SEQ_W-1:0]     out_active_seq_out,
  output logic                          out_advanced,
  output logic                          out_fell_back
);

  typedef enum logic [1:0] {
    ST_EXEC  = 2'b01,
    ST_FRAME = 2'b10
  } state_t;

  state_t                        st_r, st_nxt;
  logic [sas_pkg::SEQ_W-1:0]     default_r;
  logic [sas_pkg::SEQ_W-1:0]     active_seq_r, active_seq_nxt;
  logic [sas_pkg::POS_W-1:0]     position_r, position_nxt;
  logic                          run_back_r, run_back_nxt;
  logic [sas_pkg::STAMP_W-1:0]   last_stamp_r, last_stamp_nxt;
  logic [sas_pkg::FRAME_W-1:0]   shown_frame_r, shown_frame_nxt;
  logic                          playing_r, playing_nxt;
  logic                          adv_pend_r, adv_pend_nxt;
  logic                          fb_pend_r, fb_pend_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sas_pkg::FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic [sas_pkg::SEQ_W-1:0]     out_seq_r, out_seq_nxt;
  logic                          out_adv_r, out_adv_nxt;
  logic                          out_fb_r, out_fb_nxt;

  logic [sas_pkg::LEN_W-1:0]     len_tab  [sas_pkg::SEQ_COUNT];
  logic [sas_pkg::RATE_W-1:0]    rate_tab [sas_pkg::SEQ_COUNT];
  logic                          loop_tab [sas_pkg::SEQ_COUNT];
  logic [sas_pkg::FRAME_W-1:0]   frame_mem [sas_pkg::FRAME_DEPTH];
  logic [sas_pkg::FRAME_W-1:0]   frame_rd_r;

  logic                          out_free;
  logic                          is_play;
  logic                          tick_live;
  logic                          tick_moves;
  logic                          needs_frame;
  logic [sas_pkg::SEQ_W-1:0]     desc_addr;
  logic [sas_pkg::LEN_W-1:0]     n_len;
  logic [sas_pkg::POS_W-1:0]     n_last;
  logic [sas_pkg::STAMP_W-1:0]   stamp_due;
  logic [sas_pkg::LEN_W-1:0]     pos_inc;
  logic [sas_pkg::POS_W-1:0]     pos_dec;
  logic [sas_pkg::POS_W-1:0]     step_pos;
  logic                          step_end;
  logic [sas_pkg::SEQ_W-1:0]     fall_seq;
  logic                          mem_we;
  logic                          mem_re;
  logic [sas_pkg::FADDR_W-1:0]   mem_waddr;
  logic [sas_pkg::FADDR_W-1:0]   mem_raddr;

  assign out_free = !out_valid_r || out_ready;

  // Read the descriptor of the sequence that this item concerns
  assign is_play   = (q_item.op == sas_pkg::OP_PLAY_FWD) || (q_item.op == sas_pkg::OP_PLAY_BACK);
  assign desc_addr = is_play ? q_item.seq_id : active_seq_r;
  assign n_len     = len_tab[desc_addr];
  assign n_last    = sas_pkg::POS_W'(n_len - sas_pkg::LEN_W'(1));

  // Decide whether a tick is due to move
  assign stamp_due   = last_stamp_r + sas_pkg::STAMP_W'(rate_tab[active_seq_r]);
  assign tick_live   = (q_item.op == sas_pkg::OP_TICK) && playing_r;
  assign tick_moves  = tick_live && (last_stamp_r != '0) && (stamp_due <= q_item.time_stamp);
  assign needs_frame = is_play || tick_moves;

  // Default sequence falls to zero when out of range
  assign fall_seq = (32'(default_r) < sas_pkg::SEQ_COUNT) ? default_r : '0;

  // Step the position one entry in the run direction
  always_comb begin
    pos_inc  = {1'b0, position_r} + sas_pkg::LEN_W'(1);
    pos_dec  = position_r - sas_pkg::POS_W'(1);
    step_pos = position_r;
    step_end = 1'b0;
    if (run_back_r) begin
      if (position_r == '0) begin
        if (loop_tab[active_seq_r]) begin
          step_pos = n_last;
        end else begin
          step_end = 1'b1;
        end
      end else if ({1'b0, pos_dec} >= n_len) begin
        step_pos = n_last;
      end else begin
        step_pos = pos_dec;
      end
    end else begin
      if (pos_inc >= n_len) begin
        if (loop_tab[active_seq_r]) begin
          step_pos = '0;
        end else begin
          step_pos = n_last;
          step_end = 1'b1;
        end
      end else begin
        step_pos = sas_pkg::POS_W'(pos_inc);
      end
    end
  end

  // Sequencer: execute the head item, then collect the frame when one is fetched
  always_comb begin
    st_nxt          = st_r;
    active_seq_nxt  = active_seq_r;
    position_nxt    = position_r;
    run_back_nxt    = run_back_r;
    last_stamp_nxt  = last_stamp_r;
    shown_frame_nxt = shown_frame_r;
    playing_nxt     = playing_r;
    adv_pend_nxt    = adv_pend_r;
    fb_pend_nxt     = fb_pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_frame_nxt   = out_frame_r;
    out_seq_nxt     = out_seq_r;
    out_adv_nxt     = out_adv_r;
    out_fb_nxt      = out_fb_r;
    q_pop           = 1'b0;
    case (st_r)
      ST_EXEC: begin
        if (q_valid && (needs_frame || out_free)) begin
          q_pop = 1'b1;
          if (is_play) begin
            active_seq_nxt = q_item.seq_id;
            run_back_nxt   = (q_item.op == sas_pkg::OP_PLAY_BACK);
            position_nxt   = (q_item.op == sas_pkg::OP_PLAY_BACK) ? n_last : '0;
            last_stamp_nxt = '0;
            playing_nxt    = 1'b1;
            adv_pend_nxt   = 1'b0;
            fb_pend_nxt    = 1'b0;
            st_nxt         = ST_FRAME;
          end else if (tick_moves) begin
            last_stamp_nxt = q_item.time_stamp;
            adv_pend_nxt   = 1'b1;
            fb_pend_nxt    = step_end;
            if (step_end) begin
              active_seq_nxt = fall_seq;
              position_nxt   = '0;
            end else begin
              position_nxt   = step_pos;
            end
            st_nxt = ST_FRAME;
          end else begin
            // record the first stamp; report the unchanged state
            if (tick_live && (last_stamp_r == '0)) begin
              last_stamp_nxt = q_item.time_stamp;
            end
            out_valid_nxt = 1'b1;
            out_frame_nxt = shown_frame_r;
            out_seq_nxt   = active_seq_r;
            out_adv_nxt   = 1'b0;
            out_fb_nxt    = 1'b0;
          end
        end
      end
      ST_FRAME: begin
        if (out_free) begin
          shown_frame_nxt = frame_rd_r;
          out_valid_nxt   = 1'b1;
          out_frame_nxt   = frame_rd_r;
          out_seq_nxt     = active_seq_r;
          out_adv_nxt     = adv_pend_r;
          out_fb_nxt      = fb_pend_r;
          st_nxt          = ST_EXEC;
        end
      end
      default: begin
        st_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_EXEC;
      default_r     <= '0;
      active_seq_r  <= '0;
      position_r    <= '0;
      run_back_r    <= 1'b0;
      last_stamp_r  <= '0;
      shown_frame_r <= '0;
      playing_r     <= 1'b0;
      adv_pend_r    <= 1'b0;
      fb_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      if (cfg_we) begin
        default_r <= cfg_wdata;
      end
      active_seq_r  <= active_seq_nxt;
      position_r    <= position_nxt;
      run_back_r    <= run_back_nxt;
      last_stamp_r  <= last_stamp_nxt;
      shown_frame_r <= shown_frame_nxt;
      playing_r     <= playing_nxt;
      adv_pend_r    <= adv_pend_nxt;
      fb_pend_r     <= fb_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_frame_r <= out_frame_nxt;
    out_seq_r   <= out_seq_nxt;
    out_adv_r   <= out_adv_nxt;
    out_fb_r    <= out_fb_nxt;
  end

  // Descriptor tables
  always_ff @(posedge clk) begin
    if (q_pop && (q_item.op == sas_pkg::OP_DESC)) begin
      len_tab[q_item.seq_id]  <= q_item.seq_length;
      rate_tab[q_item.seq_id] <= q_item.seq_rate;
      loop_tab[q_item.seq_id] <= q_item.seq_loop;
    end
  end

  // Frame memory: one write port, one registered read port
  assign mem_we    = q_pop && (q_item.op == sas_pkg::OP_FRAME);
  assign mem_re    = q_pop && needs_frame;
  assign mem_waddr = {q_item.seq_id, q_item.entry_pos};
  assign mem_raddr = {active_seq_nxt, position_nxt};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= q_item.frame_value;
    end
    if (mem_re) begin
      frame_rd_r <= frame_mem[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_shown_frame_out = out_frame_r;
  assign out_active_seq_out  = out_seq_r;
  assign out_advanced        = out_adv_r;
  assign out_fell_back       = out_fb_r;

  // No item leaves the queue while a frame fetch is being collected
  a_no_pop_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FRAME) |-> !q_pop)
    else $error("item popped during frame collection");

  // A fall back is always part of an advance
  a_fb_implies_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FRAME) && fb_pend_r) |-> adv_pend_r)
    else $error("fall back pending without advance");

  // A frame fetch only happens once a sequence is playing
  a_frame_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FRAME) |-> playing_r)
    else $error("frame fetch while not playing");

  // A fetched frame becomes the shown frame when its result is loaded
  a_shown_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FRAME) && out_free) |=> (shown_frame_r == out_frame_r))
    else $error("shown frame and result disagree");

endmodule

### rtl/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer: front queue and back end.
//
// Items enter through a two-entry queue that is ready whenever it has room, so
// a new item is taken while earlier ones are still in the back end or while a
// result waits in the output register. Frame loads, descriptor loads, ticks
// that do not move and ignored requests finish in the ST_EXEC state; plays
// and ticks that move to another frame go on to ST_FRAME, which collects the
// registered read of the 1024 x 8 frame memory. Tables power up undefined and
// need no clearing pass; a sequence must be loaded before it is played.
module sprite_animation_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sas_pkg::SEQ_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sas_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sas_pkg::SEQ_W-1:0]     in_seq_id,
  input  logic [sas_pkg::POS_W-1:0]     in_entry_pos,
  input  logic [sas_pkg::FRAME_W-1:0]   in_frame_value,
  input  logic [sas_pkg::LEN_W-1:0]     in_seq_length,
  input  logic [sas_pkg::RATE_W-1:0]    in_seq_rate,
  input  logic                          in_seq_loop,
  input  logic [sas_pkg::STAMP_W-1:0]   in_time_stamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sas_pkg::FRAME_W-1:0]   out_shown_frame_out,
  output logic [sas_pkg::SEQ_W-1:0]     out_active_seq_out,
  output logic                          out_advanced,
  output logic                          out_fell_back
);

  logic           q_valid;
  logic           q_pop;
  sas_pkg::item_t q_item;

  // Classify and queue items
  sas_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_seq_id      (in_seq_id),
    .in_entry_pos   (in_entry_pos),
    .in_frame_value (in_frame_value),
    .in_seq_length  (in_seq_length),
    .in_seq_rate    (in_seq_rate),
    .in_seq_loop    (in_seq_loop),
    .in_time_stamp  (in_time_stamp),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Execute items and deliver results
  sas_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_shown_frame_out (out_shown_frame_out),
    .out_active_seq_out  (out_active_seq_out),
    .out_advanced        (out_advanced),
    .out_fell_back       (out_fell_back)
  );

endmodule

### verif/sas_frame_checker.sv
// Checker for the sprite animation sequencer: tracks playback state and compares every result.
module sas_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sas_pkg::SEQ_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [sas_pkg::REQ_W-1:0]   in_req_type,
  input  logic [sas_pkg::SEQ_W-1:0]   in_seq_id,
  input  logic [sas_pkg::POS_W-1:0]   in_entry_pos,
  input  logic [sas_pkg::FRAME_W-1:0] in_frame_value,
  input  logic [sas_pkg::LEN_W-1:0]   in_seq_length,
  input  logic [sas_pkg::RATE_W-1:0]  in_seq_rate,
  input  logic                        in_seq_loop,
  input  logic [sas_pkg::STAMP_W-1:0] in_time_stamp,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [sas_pkg::FRAME_W-1:0] out_shown_frame_out,
  input  logic [sas_pkg::SEQ_W-1:0]   out_active_seq_out,
  input  logic                        out_advanced,
  input  logic                        out_fell_back,
  output int                          mismatches,
  output int                          reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sas_pkg::FRAME_W-1:0] shown_frame;
    logic [sas_pkg::SEQ_W-1:0]   active_seq;
    logic                        advanced;
    logic                        fell_back;
  } frame_report_t;

  // Sequence store as the block should hold it
  logic [sas_pkg::FRAME_W-1:0] frame_mem [sas_pkg::SEQ_COUNT][sas_pkg::SEQ_ENTRIES];
  logic [sas_pkg::LEN_W-1:0]   len_mem   [sas_pkg::SEQ_COUNT];
  logic [sas_pkg::RATE_W-1:0]  rate_mem  [sas_pkg::SEQ_COUNT];
  logic                        loop_mem  [sas_pkg::SEQ_COUNT];

  // Playback state
  logic [sas_pkg::SEQ_W-1:0]   cur_seq;
  logic [sas_pkg::SEQ_W-1:0]   fallback_seq;
  int                          cur_pos;
  logic                        backward;
  logic                        running;
  logic [sas_pkg::STAMP_W-1:0] prev_stamp;
  logic [sas_pkg::FRAME_W-1:0] cur_frame;

  frame_report_t               reports_q [$];

  // Apply one accepted item to the playback state and return what it shows
  function automatic frame_report_t advance_player();
    frame_report_t               rep;
    int                          n;
    logic                        ended;
    logic [sas_pkg::STAMP_W-1:0] due;
    rep = '0;
    ended = 1'b0;
    case (in_req_type)
      sas_pkg::REQ_LOAD_FRAME: begin
        if (int'(in_seq_id) < sas_pkg::SEQ_COUNT && int'(in_entry_pos) < sas_pkg::SEQ_ENTRIES &&
            int'(in_frame_value) < sas_pkg::FRAME_COUNT)
          frame_mem[in_seq_id][in_entry_pos] = in_frame_value;
      end
      sas_pkg::REQ_LOAD_DESC: begin
        if (int'(in_seq_id) < sas_pkg::SEQ_COUNT) begin
          // clamp the length into 1..SEQ_ENTRIES
          n = int'(in_seq_length);
          if (n == 0) n = 1;
          if (n > sas_pkg::SEQ_ENTRIES) n = sas_pkg::SEQ_ENTRIES;
          len_mem[in_seq_id]  = sas_pkg::LEN_W'(n);
          rate_mem[in_seq_id] = in_seq_rate;
          loop_mem[in_seq_id] = in_seq_loop;
        end
      end
      sas_pkg::REQ_PLAY_FWD, sas_pkg::REQ_PLAY_BACK: begin
        if (int'(in_seq_id) < sas_pkg::SEQ_COUNT) begin
          cur_seq    = in_seq_id;
          backward   = (in_req_type == sas_pkg::REQ_PLAY_BACK);
          cur_pos    = backward ? int'(len_mem[in_seq_id]) - 1 : 0;
          cur_frame  = frame_mem[cur_seq][cur_pos];
          prev_stamp = '0;
          running    = 1'b1;
        end
      end
      sas_pkg::REQ_TICK: begin
        if (running) begin
          if (prev_stamp == '0) begin
            prev_stamp = in_time_stamp;
          end else begin
            // due time wraps at 32 bits
            due = prev_stamp + sas_pkg::STAMP_W'(rate_mem[cur_seq]);
            if (due <= in_time_stamp) begin
              n = int'(len_mem[cur_seq]);
              prev_stamp = in_time_stamp;
              rep.advanced = 1'b1;
              if (backward) begin
                if (cur_pos == 0) begin
                  if (loop_mem[cur_seq]) cur_pos = n - 1;
                  else ended = 1'b1;
                end else begin
                  cur_pos--;
                  if (cur_pos >= n) cur_pos = n - 1;
                end
              end else begin
                if (cur_pos + 1 >= n) begin
                  if (loop_mem[cur_seq]) begin
                    cur_pos = 0;
                  end else begin
                    cur_pos = n - 1;
                    ended = 1'b1;
                  end
                end else begin
                  cur_pos++;
                end
              end
              // hand over to the default sequence, keep the direction
              if (ended) begin
                cur_seq = (int'(fallback_seq) < sas_pkg::SEQ_COUNT) ? fallback_seq : '0;
                cur_pos = 0;
                rep.fell_back = 1'b1;
              end
              cur_frame = frame_mem[cur_seq][cur_pos];
            end
          end
        end
      end
      default: ;
    endcase
    rep.shown_frame = cur_frame;
    rep.active_seq  = cur_seq;
    return rep;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Track both channels; pop before queueing so a result never matches its own item
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (!rst_n) begin
      cur_seq      = '0;
      fallback_seq = '0;
      cur_pos      = 0;
      backward     = 1'b0;
      running      = 1'b0;
      prev_stamp   = '0;
      cur_frame    = '0;
      reports_q.delete();
    end else begin
      if (cfg_we) fallback_seq = cfg_wdata;
      if (out_valid && out_ready) begin
        got.shown_frame = out_shown_frame_out;
        got.active_seq  = out_active_seq_out;
        got.advanced    = out_advanced;
        got.fell_back   = out_fell_back;
        if (reports_q.size() == 0) begin
          mismatches++;
          $error("unexpected result: shown_frame_out %0d, active_seq_out %0d",
                 got.shown_frame, got.active_seq);
        end else begin
          want = reports_q.pop_front();
          compare_field("shown_frame_out", 32'(want.shown_frame), 32'(got.shown_frame));
          compare_field("active_seq_out", 32'(want.active_seq), 32'(got.active_seq));
          compare_field("advanced", 32'(want.advanced), 32'(got.advanced));
          compare_field("fell_back", 32'(want.fell_back), 32'(got.fell_back));
        end
      end
      if (in_valid && in_ready) reports_q.insert(reports_q.size(), advance_player());
    end
    reports_pending = reports_q.size();
  end

endmodule

### verif/sprite_animation_sequencer_test.sv
// Testbench top for the sprite animation sequencer: stimulus, receiver stalls and verdict.
module sprite_animation_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sas_pkg::REQ_W-1:0]   req_type;
    logic [sas_pkg::SEQ_W-1:0]   seq_id;
    logic [sas_pkg::POS_W-1:0]   entry_pos;
    logic [sas_pkg::FRAME_W-1:0] frame_value;
    logic [sas_pkg::LEN_W-1:0]   seq_length;
    logic [sas_pkg::RATE_W-1:0]  seq_rate;
    logic                        seq_loop;
    logic [sas_pkg::STAMP_W-1:0] time_stamp;
  } sprite_req_t;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 250;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [sas_pkg::SEQ_W-1:0]   cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [sas_pkg::REQ_W-1:0]   in_req_type = '0;
  logic [sas_pkg::SEQ_W-1:0]   in_seq_id = '0;
  logic [sas_pkg::POS_W-1:0]   in_entry_pos = '0;
  logic [sas_pkg::FRAME_W-1:0] in_frame_value = '0;
  logic [sas_pkg::LEN_W-1:0]   in_seq_length = '0;
  logic [sas_pkg::RATE_W-1:0]  in_seq_rate = '0;
  logic                        in_seq_loop = 1'b0;
  logic [sas_pkg::STAMP_W-1:0] in_time_stamp = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [sas_pkg::FRAME_W-1:0] out_shown_frame_out;
  logic [sas_pkg::SEQ_W-1:0]   out_active_seq_out;
  logic                        out_advanced;
  logic                        out_fell_back;
  int                          mismatches;
  int                          reports_pending;

  // What has been loaded so far, so that no unwritten entry is ever read
  bit                          written [sas_pkg::SEQ_COUNT][sas_pkg::SEQ_ENTRIES];
  bit                          described [sas_pkg::SEQ_COUNT];
  int                          rate_of [sas_pkg::SEQ_COUNT];
  logic [sas_pkg::STAMP_W-1:0] now_ts;
  int                          burst_left;
  int                          items_sent;
  int                          ready_mode;
  int                          ready_left;
  int                          ready_tick;

  always #1 clk = ~clk;

  sprite_animation_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_seq_id           (in_seq_id),
    .in_entry_pos        (in_entry_pos),
    .in_frame_value      (in_frame_value),
    .in_seq_length       (in_seq_length),
    .in_seq_rate         (in_seq_rate),
    .in_seq_loop         (in_seq_loop),
    .in_time_stamp       (in_time_stamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_shown_frame_out (out_shown_frame_out),
    .out_active_seq_out  (out_active_seq_out),
    .out_advanced        (out_advanced),
    .out_fell_back       (out_fell_back)
  );

  sas_frame_checker frame_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_seq_id           (in_seq_id),
    .in_entry_pos        (in_entry_pos),
    .in_frame_value      (in_frame_value),
    .in_seq_length       (in_seq_length),
    .in_seq_rate         (in_seq_rate),
    .in_seq_loop         (in_seq_loop),
    .in_time_stamp       (in_time_stamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_shown_frame_out (out_shown_frame_out),
    .out_active_seq_out  (out_active_seq_out),
    .out_advanced        (out_advanced),
    .out_fell_back       (out_fell_back),
    .mismatches          (mismatches),
    .reports_pending     (reports_pending)
  );

  // Receiver: switch between always ready, random, periodic and long stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(30, 200);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (ready_tick % 3 == 0);
      default: out_ready <= (ready_tick % 20 < 6);
    endcase
  end

  // Fill every field at random; callers override what the request needs
  function automatic sprite_req_t scrambled_req(input logic [sas_pkg::REQ_W-1:0] code);
    sprite_req_t r;
    r.req_type    = code;
    r.seq_id      = sas_pkg::SEQ_W'($urandom);
    r.entry_pos   = sas_pkg::POS_W'($urandom);
    r.frame_value = sas_pkg::FRAME_W'($urandom);
    r.seq_length  = sas_pkg::LEN_W'($urandom);
    r.seq_rate    = sas_pkg::RATE_W'($urandom);
    r.seq_loop    = 1'($urandom);
    r.time_stamp  = $urandom;
    return r;
  endfunction

  function automatic int frame_prefix(input int s);
    int k;
    k = 0;
    while (k < sas_pkg::SEQ_ENTRIES && written[s][k]) k++;
    return k;
  endfunction

  function automatic int pick_ready();
    int s;
    do s = $urandom_range(0, sas_pkg::SEQ_COUNT - 1); while (!described[s]);
    return s;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, (1 << sas_pkg::RATE_W) - 1);
      1: return $urandom_range(0, 1) ? (1 << sas_pkg::RATE_W) - 1 : 0;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  // Length that stays inside the frames already written for this sequence
  function automatic int legal_len(input int s);
    int p;
    p = frame_prefix(s);
    if (p == sas_pkg::SEQ_ENTRIES && $urandom_range(0, 3) == 0)
      return $urandom_range(sas_pkg::SEQ_ENTRIES + 1, (1 << sas_pkg::LEN_W) - 1);
    if ($urandom_range(0, 7) == 0) return 0;
    return $urandom_range(1, p);
  endfunction

  // Offer one item and hold it until accepted; bursts with gaps between them
  task automatic push(input sprite_req_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_req_type    <= r.req_type;
    in_seq_id      <= r.seq_id;
    in_entry_pos   <= r.entry_pos;
    in_frame_value <= r.frame_value;
    in_seq_length  <= r.seq_length;
    in_seq_rate    <= r.seq_rate;
    in_seq_loop    <= r.seq_loop;
    in_time_stamp  <= r.time_stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (r.req_type <= sas_pkg::REQ_TICK) items_sent++;
  endtask

  task automatic load_frame(input int s, input int p, input int v);
    sprite_req_t r;
    r = scrambled_req(sas_pkg::REQ_LOAD_FRAME);
    r.seq_id = sas_pkg::SEQ_W'(s);
    r.entry_pos = sas_pkg::POS_W'(p);
    r.frame_value = sas_pkg::FRAME_W'(v);
    push(r);
    written[s][p] = 1'b1;
  endtask

  task automatic load_desc(input int s, input int len, input int rate, input bit lp);
    sprite_req_t r;
    r = scrambled_req(sas_pkg::REQ_LOAD_DESC);
    r.seq_id = sas_pkg::SEQ_W'(s);
    r.seq_length = sas_pkg::LEN_W'(len);
    r.seq_rate = sas_pkg::RATE_W'(rate);
    r.seq_loop = lp;
    push(r);
    described[s] = 1'b1;
    rate_of[s] = rate;
  endtask

  task automatic send_play(input int s, input logic [sas_pkg::REQ_W-1:0] code);
    sprite_req_t r;
    r = scrambled_req(code);
    r.seq_id = sas_pkg::SEQ_W'(s);
    push(r);
  endtask

  task automatic send_tick(input logic [sas_pkg::STAMP_W-1:0] ts);
    sprite_req_t r;
    r = scrambled_req(sas_pkg::REQ_TICK);
    r.time_stamp = ts;
    push(r);
  endtask

  task automatic reload_desc(input int s);
    load_desc(s, legal_len(s), pick_rate(), 1'($urandom));
  endtask

  function automatic logic [sas_pkg::REQ_W-1:0] play_dir();
    return $urandom_range(0, 1) ? sas_pkg::REQ_PLAY_BACK : sas_pkg::REQ_PLAY_FWD;
  endfunction

  // Write a contiguous frame table from entry 0, then its descriptor
  task automatic build_seq();
    int s;
    int span;
    int len;
    s = $urandom_range(0, sas_pkg::SEQ_COUNT - 1);
    case ($urandom_range(0, 19))
      0, 1, 2: span = sas_pkg::SEQ_ENTRIES;
      3, 4, 5: span = $urandom_range(9, sas_pkg::SEQ_ENTRIES - 1);
      default: span = $urandom_range(1, 8);
    endcase
    for (int p = 0; p < span; p++)
      load_frame(s, p, $urandom_range(0, sas_pkg::FRAME_COUNT - 1));
    len = span;
    if (span == 1 && $urandom_range(0, 2) == 0) len = 0;
    if (span == sas_pkg::SEQ_ENTRIES && $urandom_range(0, 1))
      len = $urandom_range(sas_pkg::SEQ_ENTRIES + 1, (1 << sas_pkg::LEN_W) - 1);
    load_desc(s, len, pick_rate(), 1'($urandom));
  endtask

  // Start a loaded sequence and feed it ticks paced around its rate
  task automatic play_run();
    int s;
    int ticks;
    s = pick_ready();
    send_play(s, play_dir());
    ticks = $urandom_range(3, 40);
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0: begin
          now_ts = $urandom;
          send_tick(now_ts);
        end
        1: send_tick('0);
        2: reload_desc(s);
        3: begin
          now_ts = '1 - sas_pkg::STAMP_W'($urandom_range(0, 40));
          send_tick(now_ts);
        end
        default: begin
          now_ts += sas_pkg::STAMP_W'($urandom_range(0, 2 * rate_of[s] + 3));
          send_tick(now_ts);
        end
      endcase
    end
  endtask

  // Stray items between runs
  task automatic noise_item();
    case ($urandom_range(0, 5))
      0: push(scrambled_req(sas_pkg::REQ_W'($urandom_range(int'(sas_pkg::REQ_TICK) + 1,
                                                           (1 << sas_pkg::REQ_W) - 1))));
      1: load_frame($urandom_range(0, sas_pkg::SEQ_COUNT - 1),
                    $urandom_range(0, sas_pkg::SEQ_ENTRIES - 1),
                    $urandom_range(0, sas_pkg::FRAME_COUNT - 1));
      2: reload_desc(pick_ready());
      3: send_play(pick_ready(), play_dir());
      4: send_tick($urandom);
      default: begin
        now_ts += sas_pkg::STAMP_W'($urandom_range(0, 20));
        send_tick(now_ts);
      end
    endcase
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_default(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= sas_pkg::SEQ_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick before play and unknown requests change nothing
    send_tick($urandom);
    for (int c = int'(sas_pkg::REQ_TICK) + 1; c < (1 << sas_pkg::REQ_W); c++)
      push(scrambled_req(sas_pkg::REQ_W'(c)));

    // Directed: load extremes, zero length, largest rate
    load_frame(0, 0, sas_pkg::FRAME_COUNT - 1);
    load_frame(sas_pkg::SEQ_COUNT - 1, 0, 0);
    load_frame(sas_pkg::SEQ_COUNT - 1, 1, 'hA5);
    load_frame(sas_pkg::SEQ_COUNT - 1, 2, 'h3C);
    load_frame(sas_pkg::SEQ_COUNT - 1, sas_pkg::SEQ_ENTRIES - 1, 'h5A);
    load_desc(0, 0, 0, 1'b0);
    load_desc(sas_pkg::SEQ_COUNT - 1, 3, (1 << sas_pkg::RATE_W) - 1, 1'b1);

    // Directed: zero stamp, first stamp, once sequence falls back to the default
    send_play(0, sas_pkg::REQ_PLAY_FWD);
    send_tick('0);
    send_tick(5);
    send_tick(5);

    // Directed: backward start, wrapped due time, clamp after shrink
    send_play(sas_pkg::SEQ_COUNT - 1, sas_pkg::REQ_PLAY_BACK);
    send_tick('hFFFF_FFF0);
    send_tick('h10);
    load_desc(sas_pkg::SEQ_COUNT - 1, 1, (1 << sas_pkg::RATE_W) - 1, 1'b1);
    send_tick('hFFEF);

    // Directed: forward past a shrunk end, once then fall back going forward
    load_desc(sas_pkg::SEQ_COUNT - 1, 3, 0, 1'b0);
    send_play(sas_pkg::SEQ_COUNT - 1, sas_pkg::REQ_PLAY_FWD);
    send_tick('1);
    send_tick('1);
    send_tick('1);
    load_desc(sas_pkg::SEQ_COUNT - 1, 1, 0, 1'b0);
    send_tick('1);

    // Random phases, each under a default sequence that is set before it starts
    now_ts = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_default(ph == 0 ? sas_pkg::SEQ_COUNT - 1 : ph == 1 ? 0 : pick_ready());
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1, 2: build_seq();
          3, 4, 5, 6, 7: repeat ($urandom_range(1, 6)) noise_item();
          default: play_run();
        endcase
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/sas_pkg.sv
rtl/sas_front.sv
rtl/sas_back.sv
rtl/sprite_animation_sequencer.sv
verif/sas_frame_checker.sv
verif/sprite_animation_sequencer_test.sv
